/* rtl/chi_pkg.sv */
`timescale 1ns / 1ps
package chi_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CYCLE  = 2'd1,
    ST_REJECT = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_ITEM_LIMIT   = 1'b1;

  localparam int CFG_W   = 11;
  localparam int VALUE_W = 64;
  localparam int RB_W    = 10;
  localparam int EVICT_W = 11;

  typedef enum logic {
    FR_IDLE,
    FR_REDUCE
  } front_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_ROW,
    BK_SLOT
  } back_state_t;

  typedef struct packed {
    status_t            status;
    logic [RB_W-1:0]    bucket;
    logic [VALUE_W-1:0] high;
    logic [VALUE_W-1:0] low;
    logic [RB_W-1:0]    index;
    logic               occupied;
    logic [EVICT_W-1:0] evictions;
  } result_t;

endpackage

/* rtl/chi_fifo.sv */
`timescale 1ns / 1ps
module chi_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty,
  output logic         full
);

  // Two-entry queue between the front and the back.
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/chi_front.sv */
`timescale 1ns / 1ps
module chi_front import chi_pkg::*; #(
  parameter int BW     = 10,
  parameter int MW     = 11,
  parameter int HASHES = 3,
  parameter int QW     = 170
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         cmd,
  input  logic [VALUE_W-1:0] value_high,
  input  logic [VALUE_W-1:0] value_low,
  input  logic [VALUE_W-1:0] hash_word_a,
  input  logic [VALUE_W-1:0] hash_word_b,
  input  logic [VALUE_W-1:0] hash_word_c,
  input  logic [RB_W-1:0]    read_bucket,
  input  logic [MW-1:0]      modulus,
  output logic               front_busy,
  output logic               push,
  output logic [QW-1:0]      push_data
);

  localparam int CHW = HASHES * BW;

  front_state_t       state_r, state_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] words_r [3];
  logic [VALUE_W-1:0] words_nxt [3];
  logic [MW-1:0]      rem_r [3];
  logic [MW-1:0]      rem_nxt [3];
  logic [VALUE_W-1:0] hi_r, lo_r;
  logic               load;
  logic [CHW-1:0]     choices;
  logic [MW:0]        trial [3];

  assign front_busy = (state_r != FR_IDLE);

  // One restoring-division step per cycle on each of the three hash words.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l] = {rem_r[l], words_r[l][VALUE_W-1]};
      if (trial[l] >= {1'b0, modulus}) rem_nxt[l] = MW'(trial[l] - {1'b0, modulus});
      else rem_nxt[l] = MW'(trial[l]);
      words_nxt[l] = words_r[l] << 1;
    end
    for (int h = 0; h < HASHES; h++) begin
      choices[h*BW +: BW] = BW'(rem_nxt[h % 3]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    load      = 1'b0;
    push      = 1'b0;
    push_data = {2'(cmd), hi_r, lo_r, read_bucket, CHW'(0)};
    unique case (state_r)
      FR_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              load      = 1'b1;
              cnt_nxt   = 6'd0;
              state_nxt = FR_REDUCE;
            end
            CMD_READ, CMD_CLEAR: begin
              push = 1'b1;
            end
            default: ;
          endcase
        end
      end
      FR_REDUCE: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          push      = 1'b1;
          push_data = {2'(CMD_INSERT), hi_r, lo_r, RB_W'(0), choices};
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi_r       <= value_high;
      lo_r       <= value_low;
      words_r[0] <= hash_word_a;
      words_r[1] <= hash_word_b;
      words_r[2] <= hash_word_c;
      for (int l = 0; l < 3; l++) rem_r[l] <= MW'(0);
    end else if (state_r == FR_REDUCE) begin
      for (int l = 0; l < 3; l++) begin
        words_r[l] <= words_nxt[l];
        rem_r[l]   <= rem_nxt[l];
      end
    end
  end

endmodule

/* rtl/chi_back.sv */
`timescale 1ns / 1ps
module chi_back import chi_pkg::*; #(
  parameter int BUCKETS   = 1024,
  parameter int MAX_ITEMS = 1024,
  parameter int HASHES    = 3,
  parameter int BW        = 10,
  parameter int IW        = 10,
  parameter int MW        = 11,
  parameter int LW        = 11,
  parameter int QW        = 170
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [QW-1:0] q_data,
  output logic          pop,
  input  logic [MW-1:0] eff_m,
  input  logic [LW-1:0] eff_lim,
  output logic          clearing,
  output logic          res_valid,
  output result_t       res
);

  localparam int CHW = HASHES * BW;
  localparam int SW  = 1 + IW + 2 * VALUE_W;
  localparam int RW  = 2 + CHW;

  // Queue entry fields.
  cmd_t               q_cmd;
  logic [VALUE_W-1:0] q_hi, q_lo;
  logic [RB_W-1:0]    q_rb;
  logic [BW-1:0]      q_ch [HASHES];
  logic [BW-1:0]      row_ch [HASHES];

  // Slot memory: {full, item index, value high, value low}.
  logic [SW-1:0] slot_mem [BUCKETS];
  logic [SW-1:0] slot_q_r, slot_wdata;
  logic          slot_we, slot_re;
  logic [BW-1:0] slot_waddr, slot_raddr;

  // Choice memory per item: {next choice, bucket choices}.
  logic [RW-1:0] row_mem [MAX_ITEMS];
  logic [RW-1:0] row_q_r, row_wdata;
  logic          row_we, row_re;
  logic [IW-1:0] row_waddr, row_raddr;

  back_state_t        state_r, state_nxt;
  logic [BW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]      items_r, items_nxt;
  logic               failed_r, failed_nxt;
  logic [VALUE_W-1:0] cur_hi_r, cur_hi_nxt, cur_lo_r, cur_lo_nxt;
  logic [IW-1:0]      cur_idx_r, cur_idx_nxt, j_r, j_nxt;
  logic [BW-1:0]      b_r, b_nxt, landed_r, landed_nxt, landed_v;
  logic [LW-1:0]      tries_r, tries_nxt;
  result_t            res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  logic               s_full;
  logic [IW-1:0]      s_idx;
  logic [VALUE_W-1:0] s_hi, s_lo;
  logic [1:0]         nc;
  logic [1:0]         nc_next;
  logic [BW-1:0]      row_b;

  assign clearing  = (state_r == BK_CLEAR);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    q_cmd = cmd_t'(q_data[CHW+138 +: 2]);
    q_hi  = q_data[CHW+74 +: VALUE_W];
    q_lo  = q_data[CHW+10 +: VALUE_W];
    q_rb  = q_data[CHW +: RB_W];
    for (int h = 0; h < HASHES; h++) begin
      q_ch[h]   = q_data[h*BW +: BW];
      row_ch[h] = row_q_r[h*BW +: BW];
    end
    s_full = slot_q_r[SW-1];
    s_idx  = slot_q_r[2*VALUE_W +: IW];
    s_hi   = slot_q_r[VALUE_W +: VALUE_W];
    s_lo   = slot_q_r[0 +: VALUE_W];
    nc     = row_q_r[RW-1 -: 2];
    row_b  = row_ch[0];
    for (int h = 0; h < HASHES; h++) begin
      if (nc == 2'(h)) row_b = row_ch[h];
    end
    nc_next  = (nc == 2'(HASHES - 1)) ? 2'd0 : nc + 2'd1;
    landed_v = (cur_idx_r == j_r) ? b_r : landed_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    items_nxt     = items_r;
    failed_nxt    = failed_r;
    cur_hi_nxt    = cur_hi_r;
    cur_lo_nxt    = cur_lo_r;
    cur_idx_nxt   = cur_idx_r;
    j_nxt         = j_r;
    b_nxt         = b_r;
    landed_nxt    = landed_r;
    tries_nxt     = tries_r;
    res_nxt       = '0;
    res_valid_nxt = 1'b0;
    pop           = 1'b0;
    slot_we       = 1'b0;
    slot_waddr    = b_r;
    slot_wdata    = {1'b1, cur_idx_r, cur_hi_r, cur_lo_r};
    slot_re       = 1'b0;
    slot_raddr    = b_r;
    row_we        = 1'b0;
    row_waddr     = cur_idx_r;
    row_wdata     = {nc_next, row_q_r[CHW-1:0]};
    row_re        = 1'b0;
    row_raddr     = s_idx;
    unique case (state_r)
      BK_CLEAR: begin
        slot_we     = 1'b1;
        slot_waddr  = clr_cnt_r;
        slot_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + BW'(1);
        if (clr_cnt_r == BW'(BUCKETS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_cmd)
            CMD_CLEAR: begin
              res_valid_nxt  = 1'b1;
              res_nxt.status = ST_OK;
              items_nxt      = '0;
              failed_nxt     = 1'b0;
              clr_cnt_nxt    = '0;
              state_nxt      = BK_CLEAR;
            end
            CMD_READ: begin
              if (32'(q_rb) >= 32'(eff_m)) begin
                res_valid_nxt  = 1'b1;
                res_nxt.status = ST_RANGE;
              end else begin
                slot_re    = 1'b1;
                slot_raddr = BW'(q_rb);
                b_nxt      = BW'(q_rb);
                state_nxt  = BK_READ;
              end
            end
            CMD_INSERT: begin
              if (failed_r || (items_r >= eff_lim)) begin
                res_valid_nxt  = 1'b1;
                res_nxt.status = ST_REJECT;
              end else begin
                // First try uses choice zero; the stored rotation moves on to one.
                row_we      = 1'b1;
                row_waddr   = IW'(items_r);
                row_wdata   = {2'd1, q_data[CHW-1:0]};
                items_nxt   = items_r + LW'(1);
                j_nxt       = IW'(items_r);
                cur_idx_nxt = IW'(items_r);
                cur_hi_nxt  = q_hi;
                cur_lo_nxt  = q_lo;
                tries_nxt   = '0;
                landed_nxt  = '0;
                b_nxt       = q_ch[0];
                slot_re     = 1'b1;
                slot_raddr  = q_ch[0];
                state_nxt   = BK_SLOT;
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        res_valid_nxt  = 1'b1;
        res_nxt.status = ST_OK;
        res_nxt.bucket = RB_W'(b_r);
        if (s_full) begin
          res_nxt.high     = s_hi;
          res_nxt.low      = s_lo;
          res_nxt.index    = RB_W'(s_idx);
          res_nxt.occupied = 1'b1;
        end
        state_nxt = BK_IDLE;
      end
      BK_ROW: begin
        row_we     = 1'b1;
        b_nxt      = row_b;
        slot_re    = 1'b1;
        slot_raddr = row_b;
        state_nxt  = BK_SLOT;
      end
      BK_SLOT: begin
        slot_we    = 1'b1;
        landed_nxt = landed_v;
        if (!s_full) begin
          res_valid_nxt     = 1'b1;
          res_nxt.status    = ST_OK;
          res_nxt.bucket    = RB_W'(landed_v);
          res_nxt.evictions = EVICT_W'(tries_r);
          state_nxt         = BK_IDLE;
        end else begin
          cur_hi_nxt  = s_hi;
          cur_lo_nxt  = s_lo;
          cur_idx_nxt = s_idx;
          if (tries_r >= eff_lim) begin
            failed_nxt        = 1'b1;
            res_valid_nxt     = 1'b1;
            res_nxt.status    = ST_CYCLE;
            res_nxt.bucket    = (s_idx == j_r) ? RB_W'(0) : RB_W'(landed_v);
            res_nxt.evictions = EVICT_W'({1'b0, tries_r} + (LW + 1)'(1));
            state_nxt         = BK_IDLE;
          end else begin
            tries_nxt = tries_r + LW'(1);
            row_re    = 1'b1;
            row_raddr = s_idx;
            state_nxt = BK_ROW;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      items_r     <= '0;
      failed_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      items_r     <= items_nxt;
      failed_r    <= failed_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_hi_r  <= cur_hi_nxt;
    cur_lo_r  <= cur_lo_nxt;
    cur_idx_r <= cur_idx_nxt;
    j_r       <= j_nxt;
    b_r       <= b_nxt;
    landed_r  <= landed_nxt;
    tries_r   <= tries_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_q_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_q_r <= row_mem[row_raddr];
  end

endmodule

/* rtl/cuckoo_hash_insert_top.sv */
// Insert: the front reduces the hash words modulo the bucket count bit-serially,
// then the back reads the first choice's slot and writes it in the slot state;
// each eviction adds a pass through the row and slot states. Read: the back answers
// from the read state, or from idle if out of range; clear: answered from idle,
// then one row cleared per cycle. Beats may queue; the front is busy while reducing.
// Reset (synchronous, rst_n low) and clear both start a clearing pass over all
// BUCKETS rows, during which busy is high. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module cuckoo_hash_insert_top import chi_pkg::*; #(
  parameter int BUCKETS   = 1024,
  parameter int MAX_ITEMS = 1024,
  parameter int HASHES    = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [VALUE_W-1:0] in_value_high,
  input  logic [VALUE_W-1:0] in_value_low,
  input  logic [VALUE_W-1:0] in_hash_word_a,
  input  logic [VALUE_W-1:0] in_hash_word_b,
  input  logic [VALUE_W-1:0] in_hash_word_c,
  input  logic [RB_W-1:0]    in_read_bucket,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [RB_W-1:0]    out_bucket,
  output logic [VALUE_W-1:0] out_high,
  output logic [VALUE_W-1:0] out_low,
  output logic [RB_W-1:0]    out_index,
  output logic               out_occupied,
  output logic [EVICT_W-1:0] out_evictions,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  // Bucket and item index widths follow from the table sizes.
  localparam int BW  = $clog2(BUCKETS);
  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int MW  = $clog2(BUCKETS + 1);
  localparam int LW  = $clog2(MAX_ITEMS + 1);
  localparam int QW  = HASHES * BW + 2 + 2 * VALUE_W + RB_W;

  logic [CFG_W-1:0] bucket_count_r, item_limit_r;
  logic [MW-1:0]    eff_m;
  logic [LW-1:0]    eff_lim;
  logic             accept;
  logic             front_busy, push, pop, q_valid, q_full, clearing;
  logic [QW-1:0]    push_data, q_data;
  logic             res_valid;
  result_t          res;

  // Configuration registers; the user must write them only while the block is idle, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= CFG_W'(1024);
      item_limit_r   <= CFG_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        CFG_ITEM_LIMIT:   item_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A bucket count of zero acts as one; bucket counts and item limits above the table sizes saturate.
  always_comb begin
    if (bucket_count_r == '0) eff_m = MW'(1);
    else if (32'(bucket_count_r) > 32'(BUCKETS)) eff_m = MW'(BUCKETS);
    else eff_m = MW'(bucket_count_r);
    if (32'(item_limit_r) > 32'(MAX_ITEMS)) eff_lim = LW'(MAX_ITEMS);
    else eff_lim = LW'(item_limit_r);
  end

  // A new beat is taken only when the front is free, the queue has room and
  // no clearing pass is running.
  assign busy   = front_busy | q_full | clearing;
  assign accept = start & ~busy;

  chi_front #(
    .BW(BW), .MW(MW), .HASHES(HASHES), .QW(QW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .value_high  (in_value_high),
    .value_low   (in_value_low),
    .hash_word_a (in_hash_word_a),
    .hash_word_b (in_hash_word_b),
    .hash_word_c (in_hash_word_c),
    .read_bucket (in_read_bucket),
    .modulus     (eff_m),
    .front_busy  (front_busy),
    .push        (push),
    .push_data   (push_data)
  );

  chi_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  chi_back #(
    .BUCKETS(BUCKETS), .MAX_ITEMS(MAX_ITEMS), .HASHES(HASHES),
    .BW(BW), .IW(IW), .MW(MW), .LW(LW), .QW(QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .eff_m     (eff_m),
    .eff_lim   (eff_lim),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  // The result register in the back drives the ports for one cycle per beat that has a result.
  assign out_valid     = res_valid;
  assign out_status    = res.status;
  assign out_bucket    = res.bucket;
  assign out_high      = res.high;
  assign out_low       = res.low;
  assign out_index     = res.index;
  assign out_occupied  = res.occupied;
  assign out_evictions = res.evictions;

`ifndef NO_ASSERTIONS
  a_occ_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_occupied |-> out_status == ST_OK)
    else $error("occupied set on a non-ok result");
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJECT || out_status == ST_RANGE)
      |-> out_bucket == '0 && out_evictions == '0 && !out_occupied)
    else $error("rejected or out-of-range result carries data");
  a_cycle_tries : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CYCLE |-> 32'(out_evictions) == 32'(eff_lim) + 1)
    else $error("cycle result without the full try count");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import chi_pkg::*;

  localparam int NBKT   = 1024;
  localparam int NITEMS = 1024;
  localparam int NHASH  = 3;
  // A beat with no result may still be in the block when the last result shows up.
  localparam int SETTLE = 100;

  // One input beat as the sender drives it.
  typedef struct {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] vh;
    logic [VALUE_W-1:0] vl;
    logic [VALUE_W-1:0] ha;
    logic [VALUE_W-1:0] hb;
    logic [VALUE_W-1:0] hc;
    logic [RB_W-1:0]    rb;
  } beat_t;

  // A row of the directed table: either a register write or a beat, the latter
  // optionally with a result typed in by hand.
  typedef struct {
    bit         is_cfg;
    logic       reg_idx;
    logic [CFG_W-1:0] reg_val;
    beat_t      b;
    bit         has_exp;
    result_t    exp;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = CMD_INSERT;
  logic [VALUE_W-1:0] in_value_high = '0;
  logic [VALUE_W-1:0] in_value_low = '0;
  logic [VALUE_W-1:0] in_hash_word_a = '0;
  logic [VALUE_W-1:0] in_hash_word_b = '0;
  logic [VALUE_W-1:0] in_hash_word_c = '0;
  logic [RB_W-1:0]    in_read_bucket = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [RB_W-1:0]    out_bucket;
  logic [VALUE_W-1:0] out_high;
  logic [VALUE_W-1:0] out_low;
  logic [RB_W-1:0]    out_index;
  logic               out_occupied;
  logic [EVICT_W-1:0] out_evictions;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_BUCKET_COUNT;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  always #4 clk = ~clk;

  cuckoo_hash_insert_top i_dut (.*);

  // Shadow copy of the table, the per-item choices and the counters.
  logic [VALUE_W-1:0] tbl_high [NBKT];
  logic [VALUE_W-1:0] tbl_low [NBKT];
  logic [RB_W-1:0]    tbl_idx [NBKT];
  bit                 tbl_full [NBKT];
  logic [RB_W-1:0]    item_choice [NITEMS*NHASH];
  int                 item_next [NITEMS];
  int                 items_in;
  bit                 build_failed;
  logic [CFG_W-1:0]   reg_buckets = CFG_W'(1024);
  logic [CFG_W-1:0]   reg_limit = CFG_W'(1024);

  result_t expected_results[$];
  row_t    directed[$];
  int      errors = 0;
  bit      calm = 1'b0;

  function automatic int eff_buckets();
    if (reg_buckets == 0) return 1;
    if (reg_buckets > NBKT) return NBKT;
    return int'(reg_buckets);
  endfunction

  function automatic int eff_limit();
    if (reg_limit > NITEMS) return NITEMS;
    return int'(reg_limit);
  endfunction

  // Works out the result of one beat and advances the shadow state. Returns 0 for
  // a beat that produces no result.
  function automatic bit place_item(beat_t b, output result_t r);
    int m, j, idx, c, bk, landed, tries, ti;
    logic [VALUE_W-1:0] hi, lo, th, tl, hw;
    r = '{ST_OK, '0, '0, '0, '0, 1'b0, '0};
    m = eff_buckets();
    case (b.cmd)
      CMD_CLEAR: begin
        foreach (tbl_full[k]) tbl_full[k] = 1'b0;
        items_in = 0;
        build_failed = 1'b0;
        return 1'b1;
      end
      CMD_READ: begin
        if (int'(b.rb) >= m) begin
          r.status = ST_RANGE;
          return 1'b1;
        end
        r.bucket = b.rb;
        if (tbl_full[b.rb]) begin
          r.high = tbl_high[b.rb];
          r.low = tbl_low[b.rb];
          r.index = tbl_idx[b.rb];
          r.occupied = 1'b1;
        end
        return 1'b1;
      end
      CMD_INSERT: begin
        if (build_failed || items_in >= eff_limit()) begin
          r.status = ST_REJECT;
          return 1'b1;
        end
        j = items_in;
        for (int h = 0; h < NHASH; h++) begin
          hw = (h % 3 == 0) ? b.ha : (h % 3 == 1) ? b.hb : b.hc;
          item_choice[j*NHASH+h] = RB_W'(hw % VALUE_W'(m));
        end
        item_next[j] = 0;
        items_in++;
        hi = b.vh;
        lo = b.vl;
        idx = j;
        tries = 0;
        landed = 0;
        forever begin
          c = item_next[idx] % NHASH;
          bk = int'(item_choice[idx*NHASH+c]);
          item_next[idx] = (c + 1) % NHASH;
          th = tbl_high[bk];
          tl = tbl_low[bk];
          ti = int'(tbl_idx[bk]);
          tbl_high[bk] = hi;
          tbl_low[bk] = lo;
          tbl_idx[bk] = RB_W'(idx);
          if (idx == j) landed = bk;
          if (!tbl_full[bk]) begin
            tbl_full[bk] = 1'b1;
            break;
          end
          // The occupant is kicked out and carried on to its next choice.
          hi = th;
          lo = tl;
          idx = ti;
          tries++;
          if (tries >= eff_limit() + 1) begin
            build_failed = 1'b1;
            if (idx == j) landed = 0;
            r.status = ST_CYCLE;
            break;
          end
        end
        r.bucket = RB_W'(landed);
        r.evictions = EVICT_W'(tries);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", VALUE_W'(out_status), '0);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", VALUE_W'(out_status), VALUE_W'(e.status));
        if (out_bucket !== e.bucket)
          report_mismatch("bucket", VALUE_W'(out_bucket), VALUE_W'(e.bucket));
        if (out_high !== e.high) report_mismatch("high", out_high, e.high);
        if (out_low !== e.low) report_mismatch("low", out_low, e.low);
        if (out_index !== e.index)
          report_mismatch("index", VALUE_W'(out_index), VALUE_W'(e.index));
        if (out_occupied !== e.occupied)
          report_mismatch("occupied", VALUE_W'(out_occupied), VALUE_W'(e.occupied));
        if (out_evictions !== e.evictions)
          report_mismatch("evictions", VALUE_W'(out_evictions), VALUE_W'(e.evictions));
      end
    end
  end

  // Drives one beat from the falling edge and holds it until the block takes it.
  // The expectation is queued at the accepting edge, before its result.
  task automatic send_beat(beat_t b, bit has_exp, result_t exp);
    result_t r;
    bit produced;
    while (!calm && $urandom_range(99) < 29) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_cmd = b.cmd;
    in_value_high = b.vh;
    in_value_low = b.vl;
    in_hash_word_a = b.ha;
    in_hash_word_b = b.hb;
    in_hash_word_c = b.hc;
    in_read_bucket = b.rb;
    do @(posedge clk); while (busy);
    produced = place_item(b, r);
    if (produced) begin
      if (has_exp) r = exp;
      expected_results = {expected_results, r};
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  // Waits until every result is in, lets any result-less beat drain and any
  // clearing pass finish, so that a register write can follow.
  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_BUCKET_COUNT) reg_buckets = val;
    else reg_limit = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic beat_t mk(logic [1:0] cmd, logic [63:0] vh, logic [63:0] vl,
                               logic [63:0] ha, logic [63:0] hb, logic [63:0] hc,
                               logic [RB_W-1:0] rb);
    beat_t b;
    b = '{cmd, vh, vl, ha, hb, hc, rb};
    return b;
  endfunction

  task automatic add_beat(beat_t b);
    row_t r;
    r = '{1'b0, 1'b0, '0, b, 1'b0, '{ST_OK, '0, '0, '0, '0, 1'b0, '0}};
    directed = {directed, r};
  endtask

  task automatic add_checked(beat_t b, result_t e);
    row_t r;
    r = '{1'b0, 1'b0, '0, b, 1'b1, e};
    directed = {directed, r};
  endtask

  task automatic add_reg(logic idx, logic [CFG_W-1:0] val);
    row_t r;
    r = '{1'b1, idx, val, mk(CMD_INSERT, 0, 0, 0, 0, 0, 0), 1'b0,
          '{ST_OK, '0, '0, '0, '0, 1'b0, '0}};
    directed = {directed, r};
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic beat_t random_beat(bit allow_clear);
    beat_t b;
    int pick;
    pick = $urandom_range(99);
    b = mk(CMD_INSERT, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), RB_W'($urandom));
    if (pick < 30) begin
      b.cmd = CMD_READ;
      // Mostly buckets in range, so that the table contents get looked at.
      if ($urandom_range(99) < 85) b.rb = RB_W'($urandom_range(eff_buckets() - 1));
    end else if (pick < 33 && allow_clear) begin
      b.cmd = CMD_CLEAR;
    end else if (pick < 36) begin
      b.cmd = 2'd3;
    end
    return b;
  endfunction

  localparam logic [63:0] ONES = '1;

  initial begin
    // Phases of the random part: bucket count and item limit, extremes included.
    int phase_b[11] = '{1024, 7, 16, 3, 33, 64, 100, 1, 512, 2047, 0};
    int phase_l[11] = '{1024, 8, 12, 40, 40, 70, 2, 1, 1000, 5, 3};
    int sent;
    beat_t b;
    result_t nothing;

    nothing = '{ST_OK, '0, '0, '0, '0, 1'b0, '0};

    // Directed part. Right after reset the table is empty with full sizes.
    add_checked(mk(CMD_READ, 0, 0, 0, 0, 0, 0), nothing);
    add_checked(mk(CMD_INSERT, ONES, 0, 0, 0, 0, 0), nothing);
    add_checked(mk(CMD_READ, 0, 0, 0, 0, 0, 0), '{ST_OK, '0, ONES, '0, '0, 1'b1, '0});
    add_checked(mk(CMD_INSERT, 0, ONES, ONES, ONES, ONES, 0),
                '{ST_OK, 10'd1023, '0, '0, '0, 1'b0, '0});
    add_checked(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd1023),
                '{ST_OK, 10'd1023, '0, ONES, 10'd1, 1'b1, '0});
    // A collision in bucket zero sends the first item bouncing around its choices.
    add_beat(mk(CMD_INSERT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0, 5, 6, 0));
    add_beat(mk(2'd3, ONES, ONES, ONES, ONES, ONES, 10'd1023));
    add_beat(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd5));
    add_beat(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd0));
    add_checked(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), nothing);
    add_checked(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd1023), '{ST_OK, 10'd1023, '0, '0, '0, 1'b0, '0});
    // Bucket count zero acts as one; an item limit above the maximum saturates.
    add_reg(CFG_BUCKET_COUNT, '0);
    add_reg(CFG_ITEM_LIMIT, '1);
    add_checked(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd1), '{ST_RANGE, '0, '0, '0, '0, 1'b0, '0});
    add_checked(mk(CMD_INSERT, 1, 2, ONES, 3, 4, 0), nothing);
    // The second item in a single bucket evicts until the tries run out.
    add_checked(mk(CMD_INSERT, 5, 6, 7, 8, 9, 0), '{ST_CYCLE, '0, '0, '0, '0, 1'b0, 11'd1025});
    add_checked(mk(CMD_INSERT, 1, 1, 1, 1, 1, 0), '{ST_REJECT, '0, '0, '0, '0, 1'b0, '0});
    add_beat(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd0));
    add_checked(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), nothing);
    // An item limit of zero rejects everything; a limit of one takes one item.
    add_reg(CFG_ITEM_LIMIT, '0);
    add_checked(mk(CMD_INSERT, 1, 1, 1, 1, 1, 0), '{ST_REJECT, '0, '0, '0, '0, 1'b0, '0});
    add_reg(CFG_ITEM_LIMIT, 11'd1);
    add_reg(CFG_BUCKET_COUNT, 11'd1024);
    add_beat(mk(CMD_INSERT, 2, 3, 64'd77, 64'd1500, 64'd3000, 0));
    add_checked(mk(CMD_INSERT, 1, 1, 1, 1, 1, 0), '{ST_REJECT, '0, '0, '0, '0, 1'b0, '0});
    add_beat(mk(CMD_READ, 0, 0, 0, 0, 0, 10'd77));

    // Reset is held low at the start, then released; the block then clears its table while busy.
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    sent = 0;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].reg_idx, directed[i].reg_val);
      else send_beat(directed[i].b, directed[i].has_exp, directed[i].exp);
      sent++;
    end

    // Random part, phase by phase. Most phases start from a cleared table; some
    // keep the old contents so that a bucket count change lands mid-build.
    for (int p = 0; p < 11; p++) begin
      write_reg(CFG_BUCKET_COUNT, CFG_W'(phase_b[p]));
      write_reg(CFG_ITEM_LIMIT, CFG_W'(phase_l[p]));
      if (p == 0 || $urandom_range(99) < 70) send_beat(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0),
                                                       1'b0, nothing);
      for (int n = 0; n < 150; n++) begin
        calm = (p == 5);
        // Once, hold off until the block has handed back everything.
        if (p == 2 && n == 75)
          while (expected_results.size() != 0) @(negedge clk);
        b = random_beat(1'b1);
        send_beat(b, 1'b0, nothing);
      end
    end
    calm = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
